// ===== rtl/jlp_pkg.sv =====
// Package for the JSON lexical prefilter: transfer payload structs,
// reason codes, the character codes that the screen looks for and the reset nesting limit.
// No dependencies.
`default_nettype none

package jlp_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} jlp_text_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] reject_reason;
	} jlp_verdict_t;

	localparam logic [3:0] REASON_NONE         = 4'd0;
	localparam logic [3:0] REASON_TOO_DEEP     = 4'd1;
	localparam logic [3:0] REASON_STRAY_CLOSER = 4'd2;
	localparam logic [3:0] REASON_SIGN_POINT   = 4'd3;
	localparam logic [3:0] REASON_LEAD_ZERO    = 4'd4;
	localparam logic [3:0] REASON_OVERFLOW     = 4'd5;
	localparam logic [3:0] REASON_BAD_NUM_END  = 4'd6;
	localparam logic [3:0] REASON_OPEN_STRING  = 4'd7;
	localparam logic [3:0] REASON_OPEN_BRACKET = 4'd8;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_POINT     = 8'h2E;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;

	localparam logic [3:0] MAX_NESTING_RESET = 4'd2;

endpackage

`default_nettype wire

// ===== rtl/json_lexical_prefilter_unit.sv =====
// JSON lexical prefilter top level: input register, per-byte screen,
// verdict register and the APB register for the nesting limit.
// Depends on jlp_pkg.
//
// Channel   Direction  Handshake                 Payload
// text      in         text_valid / text_ready   jlp_text_t (text_byte, end_of_text)
// verdict   out        verdict_valid / ready     jlp_verdict_t (accepted, reject_reason)
// config    in         APB psel/penable/pwrite   max_nesting at any address
//
// One byte is taken per clock while the input is not stalled; a byte is screened in the
// cycle after its transfer. The end item's verdict passes through the input register
// and then the verdict register around the screen logic.
// A stalled verdict holds the next end item in the input register, which then stalls
// the input; bytes ahead of that end item keep flowing.
// Reset clears the screen state and sets max_nesting to 2.
`default_nettype none

module json_lexical_prefilter_unit #(
	parameter int NUMBER_BITS = 63
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   text_valid,
	output logic                  text_ready,
	input  jlp_pkg::jlp_text_t    text_data,
	output logic                  verdict_valid,
	input  wire                   verdict_ready,
	output jlp_pkg::jlp_verdict_t verdict_data,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [1:0]            paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import jlp_pkg::*;

	localparam int PROD_BITS = NUMBER_BITS + 4;

	logic                   valid_s1;
	jlp_text_t              text_s1;
	logic                   advance;

	logic [3:0]             max_nesting_q;
	logic                   in_string_q, escape_q, in_number_q, rejected_q;
	logic [3:0]             level_q, reason_q;
	logic [NUMBER_BITS-1:0] number_q;

	logic                   in_string_d, escape_d, in_number_d, rejected_d;
	logic [3:0]             level_d, reason_d;
	logic [NUMBER_BITS-1:0] number_d;
	logic [3:0]             verdict_reason;

	logic [7:0]             b;
	logic                   is_digit, is_num_end, pass;
	logic [3:0]             digit;
	logic [PROD_BITS-1:0]   prod;
	logic                   overflow;
	logic                   paddr_unused;

	assign pready = 1'b1;
	assign prdata = {28'd0, max_nesting_q};
	assign paddr_unused = paddr[0] ^ paddr[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nesting_q <= MAX_NESTING_RESET;
		end else if (psel && penable && pwrite && (paddr_unused || !paddr_unused)) begin
			max_nesting_q <= pwdata[3:0];
		end
	end

	assign advance    = valid_s1 && (!text_s1.end_of_text || !verdict_valid || verdict_ready);
	assign text_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			text_s1 <= text_data;
		end
	end

	assign b          = text_s1.text_byte;
	assign digit      = b[3:0];
	assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
	assign is_num_end = b inside {CH_COMMA, CH_RBRACE, CH_RBRACKET, CH_SPACE,
		CH_TAB, CH_CR, CH_LF};
	assign prod = {1'b0, number_q, 3'b000} + {3'b000, number_q, 1'b0}
		+ {{(PROD_BITS-4){1'b0}}, digit};
	assign overflow = |prod[PROD_BITS-1:NUMBER_BITS];

	always_comb begin
		if (rejected_q) begin
			verdict_reason = reason_q;
		end else if (in_string_q) begin
			verdict_reason = REASON_OPEN_STRING;
		end else if (level_q != 4'd0) begin
			verdict_reason = REASON_OPEN_BRACKET;
		end else begin
			verdict_reason = REASON_NONE;
		end
	end

	always_comb begin
		in_string_d = in_string_q;
		escape_d    = escape_q;
		level_d     = level_q;
		in_number_d = in_number_q;
		number_d    = number_q;
		rejected_d  = rejected_q;
		reason_d    = reason_q;
		pass        = 1'b1;
		if (text_s1.end_of_text) begin
			in_string_d = 1'b0;
			escape_d    = 1'b0;
			level_d     = 4'd0;
			in_number_d = 1'b0;
			number_d    = '0;
			rejected_d  = 1'b0;
			reason_d    = REASON_NONE;
		end else if (!rejected_q) begin
			if (in_string_q) begin
				if (escape_q) begin
					escape_d = 1'b0;
				end else if (b == CH_BACKSLASH) begin
					escape_d = 1'b1;
				end else if (b == CH_QUOTE) begin
					in_string_d = 1'b0;
				end
			end else begin
				if (in_number_q) begin
					if (is_digit) begin
						pass = 1'b0;
						if (number_q == '0) begin
							rejected_d = 1'b1;
							reason_d   = REASON_LEAD_ZERO;
						end else if (overflow) begin
							rejected_d = 1'b1;
							reason_d   = REASON_OVERFLOW;
						end else begin
							number_d = prod[NUMBER_BITS-1:0];
						end
					end else begin
						in_number_d = 1'b0;
						number_d    = '0;
						if (!is_num_end) begin
							pass       = 1'b0;
							rejected_d = 1'b1;
							reason_d   = REASON_BAD_NUM_END;
						end
					end
				end
				if (pass) begin
					if (b == CH_QUOTE) begin
						in_string_d = 1'b1;
					end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
						if ({1'b0, level_q} + 5'd1 > {1'b0, max_nesting_q}) begin
							rejected_d = 1'b1;
							reason_d   = REASON_TOO_DEEP;
						end else begin
							level_d = level_q + 4'd1;
						end
					end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
						if (level_q == 4'd0) begin
							rejected_d = 1'b1;
							reason_d   = REASON_STRAY_CLOSER;
						end else begin
							level_d = level_q - 4'd1;
						end
					end else if (b inside {CH_MINUS, CH_PLUS, CH_POINT}) begin
						rejected_d = 1'b1;
						reason_d   = REASON_SIGN_POINT;
					end else if (is_digit) begin
						in_number_d = 1'b1;
						number_d    = {{(NUMBER_BITS-4){1'b0}}, digit};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			escape_q    <= 1'b0;
			level_q     <= 4'd0;
			in_number_q <= 1'b0;
			number_q    <= '0;
			rejected_q  <= 1'b0;
			reason_q    <= REASON_NONE;
		end else if (advance) begin
			in_string_q <= in_string_d;
			escape_q    <= escape_d;
			level_q     <= level_d;
			in_number_q <= in_number_d;
			number_q    <= number_d;
			rejected_q  <= rejected_d;
			reason_q    <= reason_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid <= 1'b0;
		end else if (advance && text_s1.end_of_text) begin
			verdict_valid <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && text_s1.end_of_text) begin
			verdict_data.accepted      <= (verdict_reason == REASON_NONE);
			verdict_data.reject_reason <= verdict_reason;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/jlp_checker.sv =====
// Port-level checker for the JSON lexical prefilter, bound to the top level.
// Depends on jlp_pkg and json_lexical_prefilter_unit.
`default_nettype none

module jlp_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   text_valid,
	input wire                   text_ready,
	input jlp_pkg::jlp_text_t    text_data,
	input wire                   verdict_valid,
	input wire                   verdict_ready,
	input jlp_pkg::jlp_verdict_t verdict_data,
	input wire                   psel,
	input wire                   penable,
	input wire                   pwrite,
	input wire  [1:0]            paddr,
	input wire  [31:0]           pwdata,
	input wire  [31:0]           prdata,
	input wire                   pready
);
	import jlp_pkg::*;

	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict_data))
		else $error("verdict dropped or changed while stalled");

	a_accept_match: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> verdict_data.accepted == (verdict_data.reject_reason == REASON_NONE))
		else $error("accepted flag disagrees with reject reason");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> verdict_data.reject_reason <= REASON_OPEN_BRACKET)
		else $error("reject reason out of range");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=> prdata == {28'd0, $past(pwdata[3:0])})
		else $error("nesting limit readback does not match the write");

endmodule

bind json_lexical_prefilter_unit jlp_checker u_jlp_checker (.*);

`default_nettype wire
